FILE: hw/rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SKTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SKTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/skts_pkg.sv
// ----------------------------------------------------------------------------
// skts_pkg
// Shared constants for the sorted key table search unit.
// ----------------------------------------------------------------------------
`default_nettype none

package skts_pkg;

    // table size and derived widths
    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);

    // fixed field widths
    localparam int KEY_W   = 64;
    localparam int ENTRY_W = 10;
    localparam int POS_W   = 11;
    localparam int OP_W    = 2;

    // stream packing
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 16;

    // operation codes
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND  = 2'd1;
    localparam logic [OP_W-1:0] OP_LOWER = 2'd2;

endpackage

`default_nettype wire

FILE: hw/rtl/skts_ram.sv
// ----------------------------------------------------------------------------
// skts_ram
// Simple dual-port RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module skts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sorted_key_table_search_unit.sv
// ----------------------------------------------------------------------------
// sorted_key_table_search_unit
// Sorted 64-bit key table with exact-find and lower-bound binary search.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_axis    in         tuser: operation; tdata: key, entry_index,
//                       range_start, range_end
//  m_axis    out        tuser: found; tdata: position
//  cfg       in         entry_count
//
//  a write item gives no result
//  a search passes START, one LOOK state per halving step (up to 11 for
//  1024 entries) and DONE, which loads the output register
//  the step rate is set by the single read port of the key table
//  a finished result waits in DONE while the output register is still full
//  rst_n clears control state only; table contents are undefined until written
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table_search_unit
    import skts_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [63:0] key, [73:64] entry_index, [84:74] range_start, [95:85] range_end
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] operation
    input  wire logic [OP_W-1:0]       s_axis_tuser,
    // result stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [10:0] position, [15:11] zero
    output logic      [OUT_DATA_W-1:0] m_axis_tdata,
    // [0] found
    output logic                       m_axis_tuser,
    // configuration write
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [POS_W-1:0]      cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_LOOK,
        ST_DONE
    } state_t;

    localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);

    state_t             state_reg;
    logic [POS_W-1:0]   entry_count_reg;
    logic               out_valid_reg;
    logic               out_found_reg;
    logic [POS_W-1:0]   out_pos_reg;
    logic               res_found_reg;
    logic [POS_W-1:0]   res_pos_reg;

    // search payload
    logic [KEY_W-1:0]   key_reg;
    logic               exact_reg;
    logic [POS_W-1:0]   lo_reg;
    logic [POS_W-1:0]   he_reg;
    logic [POS_W-1:0]   mid_reg;
    logic [POS_W-1:0]   re_reg;

    // input fields
    logic [KEY_W-1:0]   in_key;
    logic [ENTRY_W-1:0] in_entry;
    logic [POS_W-1:0]   in_start;
    logic [POS_W-1:0]   in_end;
    logic [POS_W-1:0]   end_clamped;
    logic [POS_W-1:0]   count_clamped;
    logic               in_xfer;

    // step datapath
    logic [KEY_W-1:0]   rd_key;
    logic               rd_lt;
    logic               rd_eq;
    logic               hit;
    logic [POS_W-1:0]   step_lo;
    logic [POS_W-1:0]   step_he;
    logic [POS_W:0]     mid_sum;
    logic [POS_W-1:0]   step_mid;
    logic               step_more;
    logic               ram_we;
    logic               ram_re;

    assign in_key   = s_axis_tdata[63:0];
    assign in_entry = s_axis_tdata[73:64];
    assign in_start = s_axis_tdata[84:74];
    assign in_end   = s_axis_tdata[95:85];

    assign end_clamped   = (in_end > CAP_POS) ? CAP_POS : in_end;
    assign count_clamped = (entry_count_reg > CAP_POS) ? CAP_POS : entry_count_reg;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tdata  = OUT_DATA_W'(out_pos_reg);

    // table write on a write transfer inside the table
    assign ram_we = in_xfer && (s_axis_tuser == OP_WRITE) && (32'(in_entry) < CAPACITY);

    // one halving step: compare the probed key, narrow the window, pick the next probe
    always_comb
    begin
        rd_lt = rd_key < key_reg;
        rd_eq = rd_key == key_reg;
        hit   = (state_reg == ST_LOOK) && exact_reg && rd_eq;
        if (state_reg == ST_LOOK)
        begin
            step_lo = rd_lt ? (mid_reg + POS_W'(1)) : lo_reg;
            step_he = rd_lt ? he_reg : mid_reg;
        end
        else
        begin
            step_lo = lo_reg;
            step_he = he_reg;
        end
        // exact find probes floor((lo + hi) / 2) with hi = he - 1
        mid_sum   = {1'b0, step_lo} + {1'b0, step_he} - (POS_W + 1)'(exact_reg);
        step_mid  = mid_sum[POS_W:1];
        step_more = step_lo < step_he;
        ram_re    = ((state_reg == ST_START) || (state_reg == ST_LOOK)) && !hit && step_more;
    end

    skts_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(in_entry)),
        .wdata (in_key),
        .re    (ram_re),
        .raddr (ADDR_W'(step_mid)),
        .rdata (rd_key)
    );

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            entry_count_reg <= cfg_data;
        end
    end

    // key loaded on any transfer, search window on a search transfer, narrowed by each step
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            key_reg <= in_key;
            unique case (s_axis_tuser)
                OP_FIND:
                begin
                    exact_reg <= 1'b1;
                    lo_reg    <= '0;
                    he_reg    <= count_clamped;
                    re_reg    <= count_clamped;
                end
                OP_LOWER:
                begin
                    exact_reg <= 1'b0;
                    re_reg    <= end_clamped;
                    // an empty or inverted range collapses onto its end
                    lo_reg    <= (in_start < end_clamped) ? in_start : end_clamped;
                    he_reg    <= end_clamped;
                end
                default:
                begin
                    exact_reg <= exact_reg;
                end
            endcase
        end
        else if ((state_reg == ST_START) || (state_reg == ST_LOOK))
        begin
            lo_reg  <= step_lo;
            he_reg  <= step_he;
            mid_reg <= step_mid;
        end
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_found_reg <= 1'b0;
            out_pos_reg   <= '0;
            res_found_reg <= 1'b0;
            res_pos_reg   <= '0;
        end
        else
        begin
            // output transfer empties the register unless DONE refills it
            if (m_axis_tready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer && ((s_axis_tuser == OP_FIND) || (s_axis_tuser == OP_LOWER)))
                    begin
                        state_reg <= ST_START;
                    end
                end
                ST_START, ST_LOOK:
                begin
                    if (hit)
                    begin
                        res_found_reg <= 1'b1;
                        res_pos_reg   <= mid_reg;
                        state_reg     <= ST_DONE;
                    end
                    else if (step_more)
                    begin
                        state_reg <= ST_LOOK;
                    end
                    else
                    begin
                        res_found_reg <= !exact_reg && (step_lo < re_reg);
                        res_pos_reg   <= exact_reg ? '0 : step_lo;
                        state_reg     <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_found_reg <= res_found_reg;
                        out_pos_reg   <= res_pos_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/skts_checker.sv
// ----------------------------------------------------------------------------
// skts_checker
// Port-level checks for the sorted key table search unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module skts_checker
    import skts_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic [OP_W-1:0]       s_axis_tuser,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic                  m_axis_tuser
);

    logic search_xfer;
    logic write_xfer;

    assign search_xfer = s_axis_tvalid && s_axis_tready &&
                         ((s_axis_tuser == OP_FIND) || (s_axis_tuser == OP_LOWER));
    assign write_xfer  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_WRITE);

    // after a search transfer the unit is busy and the input is not ready
    `SKTS_ASSERT_NEXT(a_search_busy, search_xfer, !s_axis_tready, "input taken during search")

    // a write never produces a result
    `SKTS_ASSERT_NEXT(a_write_silent, write_xfer, !$rose(m_axis_tvalid), "result after write")

    // a found position lies inside the table
    `SKTS_ASSERT_NOW(a_found_in_table, m_axis_tvalid && m_axis_tuser,
        m_axis_tdata < OUT_DATA_W'(CAPACITY), "found position outside table")

    // position never exceeds the table size and padding stays zero
    `SKTS_ASSERT_NOW(a_pos_range, m_axis_tvalid,
        m_axis_tdata <= OUT_DATA_W'(CAPACITY), "position out of range")

    // a stalled result holds
    `SKTS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind sorted_key_table_search_unit skts_checker u_skts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
